>>> rtl/cs_pkg.sv
// Shared types, constants and the arctangent table for the CORDIC sine unit.
package cs_pkg;

    localparam int CS_W = 32;
    localparam int CS_TABLE_DEPTH = 32;

    localparam logic [CS_W-1:0] CS_GAIN = 32'h26DC_EDB0;
    localparam logic [CS_W-1:0] CS_HALF = 32'h8000_0000;
    localparam logic signed [CS_W-1:0] CS_ONE = 32'sh4000_0000;
    localparam logic signed [CS_W-1:0] CS_MINUS_ONE = -32'sh4000_0000;

    typedef logic [CS_W-1:0] cs_word_t;

    // Rotation state handed from one cell to the next.
    typedef struct packed {
        cs_word_t x;
        cs_word_t y;
        cs_word_t z;
    } cs_rot_t;

    localparam cs_word_t CS_ATAN [32] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
    };

    // Arctangent of 2^-k; steps past the end of the table use zero.
    function automatic cs_word_t cs_atan_at(input int k);
        cs_word_t a;
        a = '0;
        if (k >= 0 && k < CS_TABLE_DEPTH && k < 32)
        begin
            a = CS_ATAN[k];
        end
        return a;
    endfunction

endpackage

>>> rtl/cs_cell.sv
// One CORDIC rotation step with its pipeline register.
module cs_cell #(
    parameter int K = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  cs_pkg::cs_rot_t in_rot,
    output logic            out_valid,
    output cs_pkg::cs_rot_t out_rot
);
    import cs_pkg::*;

    localparam cs_word_t ATAN = cs_atan_at(K);
    localparam int SHIFT = K % 32;

    logic     valid_reg;
    cs_rot_t  rot_reg;
    cs_rot_t  rot_next;
    cs_word_t dx;
    cs_word_t dy;

    // Shifted cross terms; the sign of the residual angle picks the direction.
    always_comb
    begin
        dx = cs_word_t'($signed(in_rot.y) >>> SHIFT);
        dy = cs_word_t'($signed(in_rot.x) >>> SHIFT);
        if (!in_rot.z[CS_W-1])
        begin
            rot_next.x = in_rot.x - dx;
            rot_next.y = in_rot.y + dy;
            rot_next.z = in_rot.z - ATAN;
        end
        else
        begin
            rot_next.x = in_rot.x + dx;
            rot_next.y = in_rot.y - dy;
            rot_next.z = in_rot.z + ATAN;
        end
    end

    // Valid flag is control and gets reset; the word itself does not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rot_reg <= rot_next;
    end

    assign out_valid = valid_reg;
    assign out_rot   = rot_reg;

endmodule

>>> rtl/cordic_sine_unit.sv
// Top level of the pipelined CORDIC sine unit.
// The unit takes one angle word every clock and never raises busy. Each word
// passes a folding stage, ITERATIONS rotation cells and a saturating output
// register before its sine appears with done high. The receiver cannot
// stall the unit and must take each result in the cycle it is shown.
module cordic_sine_unit #(
    parameter int ITERATIONS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] angle,
    output logic        done,
    output logic [31:0] sine
);
    import cs_pkg::*;

    logic     stage_valid [ITERATIONS+1];
    cs_rot_t  stage_rot   [ITERATIONS+1];

    logic     fold_valid_reg;
    cs_rot_t  fold_rot_reg;
    cs_word_t z_fold;

    logic     done_reg;
    cs_word_t sine_reg;
    cs_word_t sine_next;
    cs_word_t y_last;

    // The pipeline takes a word every cycle.
    assign busy = 1'b0;

    // Fold angles from a quarter turn up to below three quarters of a turn to half a turn minus the angle.
    always_comb
    begin
        if (angle[CS_W-1] ^ angle[CS_W-2])
        begin
            z_fold = CS_HALF - angle;
        end
        else
        begin
            z_fold = angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_valid_reg <= 1'b0;
        end
        else
        begin
            fold_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        fold_rot_reg.x <= CS_GAIN;
        fold_rot_reg.y <= '0;
        fold_rot_reg.z <= z_fold;
    end

    assign stage_valid[0] = fold_valid_reg;
    assign stage_rot[0]   = fold_rot_reg;

    // Chain of rotation cells.
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_cell
        cs_cell #(
            .K(i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (stage_valid[i]),
            .in_rot   (stage_rot[i]),
            .out_valid(stage_valid[i+1]),
            .out_rot  (stage_rot[i+1])
        );
    end

    // Clamp the final y to plus or minus one in Q2.30.
    assign y_last = stage_rot[ITERATIONS].y;

    always_comb
    begin
        if ($signed(y_last) > CS_ONE)
        begin
            sine_next = CS_ONE;
        end
        else if ($signed(y_last) < CS_MINUS_ONE)
        begin
            sine_next = CS_MINUS_ONE;
        end
        else
        begin
            sine_next = y_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_valid[ITERATIONS];
        end
    end

    always_ff @(posedge clk)
    begin
        sine_reg <= sine_next;
    end

    assign done = done_reg;
    assign sine = sine_reg;

endmodule

>>> dv/cordic_sine_unit_test.sv
// Self-checking testbench for the CORDIC sine unit: folding, rotation and saturation.
module cordic_sine_unit_test;

    localparam int ITER = 20;
    localparam int CLK_HALF = 2;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_WORDS = 550;

    // Arctangent of 2^-k, a full turn being 2^32.
    localparam logic [31:0] ATAN_TABLE [32] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
    };

    typedef struct {
        logic [31:0] phase;
        logic [31:0] sine;
    } sine_entry_t;

    // Holds the sines still owed by the unit, oldest first, and checks each result word.
    class sine_scoreboard;
        sine_entry_t pending_sines[$];
        int          angles_in;
        int          sines_out;
        int          mismatches;

        // Folds the angle into the right half plane, rotates and clamps the sine.
        function logic [31:0] cordic_sine_of(input logic [31:0] phase);
            logic signed [31:0] x;
            logic signed [31:0] y;
            logic signed [31:0] z;
            logic signed [31:0] dx;
            logic signed [31:0] dy;
            logic [31:0]        step_angle;
            x = 32'h26DC_EDB0;
            y = '0;
            if ((!phase[31] && phase >= 32'h4000_0000) || (phase[31] && phase < 32'hC000_0000))
            begin
                z = 32'h8000_0000 - phase;
            end
            else
            begin
                z = phase;
            end
            for (int k = 0; k < ITER; k++)
            begin
                dx = y >>> k;
                dy = x >>> k;
                step_angle = (k < 32) ? ATAN_TABLE[k] : 32'h0;
                if (!z[31])
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - step_angle;
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + step_angle;
                end
            end
            if (y > 32'sh4000_0000)
            begin
                y = 32'sh4000_0000;
            end
            else if (y < -32'sh4000_0000)
            begin
                y = -32'sh4000_0000;
            end
            return y;
        endfunction

        // An angle word was taken by the unit.
        function void note_angle(input logic [31:0] phase);
            sine_entry_t e;
            e.phase = phase;
            e.sine = cordic_sine_of(phase);
            pending_sines.push_back(e);
            angles_in++;
        endfunction

        // A sine word was shown by the unit.
        function void check_sine(input logic [31:0] sine);
            sine_entry_t e;
            sines_out++;
            if (pending_sines.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected sine word, expected none, actual %h", $time, sine);
            end
            else
            begin
                e = pending_sines.pop_front();
                if (sine !== e.sine)
                begin
                    mismatches++;
                    $display("%0t: sine mismatch for angle %h: expected %h, actual %h",
                             $time, e.phase, e.sine, sine);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] angle;
    logic        done;
    logic [31:0] sine;

    sine_scoreboard sb = new;
    int stall_cycles;

    cordic_sine_unit #(
        .ITERATIONS(ITER)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .angle(angle),
        .done (done),
        .sine (sine)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Observe both sides at the rising edge and count cycles in which nothing moves.
    always @(posedge clk)
    begin
        if (rst_n && ((start && !busy) || done))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (rst_n && start && !busy)
        begin
            sb.note_angle(angle);
        end
        if (rst_n && done)
        begin
            sb.check_sine(sine);
        end
    end

    // Watchdog: the run is stuck when nothing has been accepted or returned for too long.
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("Watchdog expired after %0d quiet cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Present one angle word, after random idle cycles, and hold it until taken.
    task automatic send_angle(input logic [31:0] phase, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        angle <= phase;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        @(negedge clk);
    endtask

    // Full-range phases mixed with phases close to the fold points, the half turn and zero.
    function automatic logic [31:0] random_angle();
        logic [31:0] base;
        case ($urandom_range(3))
            0: base = 32'h4000_0000;
            1: base = 32'hC000_0000;
            2: base = 32'h8000_0000;
            default: base = 32'h0000_0000;
        endcase
        case ($urandom_range(3))
            0, 1: return $urandom;
            2: return base + $urandom_range(64) - 32;
            default: return base + $urandom_range(32'h0002_0000) - 32'h0001_0000;
        endcase
    endfunction

    // Lower start and wait until every owed sine has come back.
    task automatic drain_sines();
        start <= 1'b0;
        while (sb.pending_sines.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] directed [$];
        rst_n = 1'b0;
        start = 1'b0;
        angle = '0;
        repeat (7)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words: zero, quarter and half turns, both fold boundaries and their neighbors.
        directed = '{32'h0000_0000, 32'h4000_0000, 32'hC000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h3FFF_FFFF, 32'h4000_0001, 32'hBFFF_FFFF,
                     32'hC000_0001, 32'h2000_0000, 32'hE000_0000, 32'h6000_0000,
                     32'hA000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'h8000_0001, 32'h3FFF_FF00, 32'hC000_0100};
        foreach (directed[i])
        begin
            send_angle(directed[i], 0);
        end
        drain_sines();

        // Random words with the sender idling often, then a full drain.
        repeat (PHASE_WORDS)
        begin
            send_angle(random_angle(), 27);
        end
        drain_sines();
        repeat (PHASE_WORDS)
        begin
            send_angle(random_angle(), 56);
        end
        repeat (PHASE_WORDS)
        begin
            send_angle(random_angle(), 0);
        end
        start <= 1'b0;

        while (sb.pending_sines.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (ITER + 8)
        begin
            @(posedge clk);
        end

        $display("Drove %0d angles (fold points, half turns, random phases); checked %0d sines.",
                 sb.angles_in, sb.sines_out);
        $display("Sender idle profiles: 27, 56 and 0 percent; %0d mismatches.", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_sines.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
